### rtl/spd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants
// Word formats, status codes and size defaults for the shortest path unit.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int MAX_NODES_DEF   = 64;
  localparam int MAX_EDGES_DEF   = 1024;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int VERTEX_W = 6;
  localparam int DIST_W   = 22;
  localparam int PRED_W   = 7;
  localparam int NODE_W   = PRED_W + DIST_W;

  localparam logic [DIST_W-1:0] DIST_CAP = 22'h3FFFFF;
  localparam logic [DIST_W:0]   DIST_INF = 23'h400000;
  localparam logic [PRED_W-1:0] NO_PRED  = 7'd64;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] ST_PATH      = 3'd0;
  localparam logic [2:0] ST_NO_PATH   = 3'd1;
  localparam logic [2:0] ST_STORED    = 3'd2;
  localparam logic [2:0] ST_EDGE_BAD  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_QUERY_BAD = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  edge_from;
    logic [5:0]  edge_to;
    logic [15:0] edge_cost;
    logic [5:0]  query_start;
    logic [5:0]  query_end;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  vertex;
    logic [21:0] total_distance;
    logic [2:0]  status;
    logic        last;
  } out_word_t;

endpackage

### rtl/shortest_path_dijkstra_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_dijkstra_unit: array-scan shortest path engine
// Stores directed weighted edges and answers start/end path queries.
//
//   channel | direction | handshake           | word
//   in      | input     | in_valid/in_ready   | spd_pkg::in_word_t
//   out     | output    | out_valid/out_ready | spd_pkg::out_word_t
//   cfg     | input     | APB psel/penable    | node_count at address 0
//
// Add edge, clear, bad vertex, full table and start-equals-end each finish
// before the next accept. A query runs at most n-1 rounds (scan of all n
// nodes, select, list head, then a read of each edge on the list and a
// relaxation for each edge not skipped), then walks back over the path and
// emits one result per path vertex; the node memory has a single read port,
// so the scan reads the nodes one at a time.
// Reset clears the list heads (valid bits), edge count and node_count=64.
// in_ready is low while an item is in work; a result waiting in the output
// register does not stall the next item until the next result is due.
// ----------------------------------------------------------------------------
module shortest_path_dijkstra_unit #(
  parameter int MAX_NODES   = spd_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = spd_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = spd_pkg::WEIGHT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  spd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spd_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NA = $clog2(MAX_NODES);
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int LB = $clog2(MAX_EDGES + 1);
  localparam int TW = spd_pkg::VERTEX_W + WEIGHT_BITS + LB;
  localparam logic [LB-1:0] EDGE_NULL = LB'(MAX_EDGES);
  localparam logic [6:0]    NODES_MAX = 7'(MAX_NODES);

  // sequencer codes
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_RES     = 5'd1;
  localparam logic [4:0] S_ADD     = 5'd2;
  localparam logic [4:0] S_ADD_WR  = 5'd3;
  localparam logic [4:0] S_ROUND   = 5'd4;
  localparam logic [4:0] S_SCAN    = 5'd5;
  localparam logic [4:0] S_SEL     = 5'd6;
  localparam logic [4:0] S_HEAD    = 5'd7;
  localparam logic [4:0] S_EDGE    = 5'd8;
  localparam logic [4:0] S_EDGE_RD = 5'd9;
  localparam logic [4:0] S_REL     = 5'd10;
  localparam logic [4:0] S_DRD     = 5'd11;
  localparam logic [4:0] S_DCHK    = 5'd12;
  localparam logic [4:0] S_WALK    = 5'd13;
  localparam logic [4:0] S_WALK_RD = 5'd14;
  localparam logic [4:0] S_EMIT    = 5'd15;
  localparam logic [4:0] S_EMIT_LD = 5'd16;

  logic [4:0]  state;
  logic [6:0]  node_count;
  logic [6:0]  n_eff;
  spd_pkg::in_word_t item;

  // graph bookkeeping
  logic [MAX_NODES-1:0] head_valid;
  logic [LB-1:0]        edges_used;

  // query working state
  logic [MAX_NODES-1:0] touched;   // node has a finite distance
  logic [MAX_NODES-1:0] done;
  logic [6:0]           rnd;
  logic [6:0]           scan_j;
  logic                 scan_pv;
  logic [NA-1:0]        scan_jd;
  logic [spd_pkg::DIST_W:0] min_d;
  logic                 u_none;
  logic [NA-1:0]        u_sel;
  logic [LB-1:0]        p;
  logic [spd_pkg::DIST_W-1:0] tot;
  logic [6:0]           walk_v;
  logic [6:0]           cnt;
  logic [6:0]           idx;

  // pending single result
  logic [2:0]                    res_status;
  logic [spd_pkg::VERTEX_W-1:0]  res_vertex;

  // memory ports
  logic          hd_we;
  logic [NA-1:0] hd_addr;
  logic [LB-1:0] hd_wdata, hd_rdata;
  logic          ed_we;
  logic [EA-1:0] ed_addr;
  logic [TW-1:0] ed_wdata, ed_rdata;
  logic          nd_we;
  logic [NA-1:0] nd_waddr, nd_raddr;
  logic [spd_pkg::NODE_W-1:0] nd_wdata, nd_rdata;
  logic          pb_we;
  logic [NA-1:0] pb_raddr;
  logic [spd_pkg::VERTEX_W-1:0] pb_rdata;

  spd_edge_store #(
    .MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .NA(NA), .EA(EA), .LB(LB), .TW(TW)
  ) u_edges (
    .clk, .hd_we, .hd_addr, .hd_wdata, .hd_rdata,
    .ed_we, .ed_addr, .ed_wdata, .ed_rdata
  );

  spd_node_table #(.MAX_NODES(MAX_NODES), .NA(NA)) u_nodes (
    .clk, .nd_we, .nd_waddr, .nd_wdata, .nd_raddr, .nd_rdata,
    .pb_we, .pb_waddr(cnt[NA-1:0]), .pb_wdata(walk_v[spd_pkg::VERTEX_W-1:0]),
    .pb_raddr, .pb_rdata
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {25'd0, node_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 7'd64;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      node_count <= pwdata[6:0];
    end
  end

  // clamp the vertex count to 1..MAX_NODES
  always_comb begin
    if (node_count == 7'd0) n_eff = 7'd1;
    else if (node_count > NODES_MAX) n_eff = NODES_MAX;
    else n_eff = node_count;
  end

  assign in_ready = (state == S_IDLE);
  wire accept = in_valid && in_ready;
  wire out_free = !out_valid || out_ready;
  // a new word enters the output register this cycle
  wire out_load = out_free && (state == S_RES || state == S_EMIT_LD);

  // decoded edge record
  wire [spd_pkg::VERTEX_W-1:0] e_tgt = ed_rdata[TW-1 -: spd_pkg::VERTEX_W];
  wire [WEIGHT_BITS-1:0]       e_wt  = ed_rdata[LB +: WEIGHT_BITS];
  wire [LB-1:0]                e_lnk = ed_rdata[LB-1:0];

  wire [spd_pkg::DIST_W-1:0] nd_dist = nd_rdata[spd_pkg::DIST_W-1:0];
  wire [spd_pkg::PRED_W-1:0] nd_pred = nd_rdata[spd_pkg::NODE_W-1 -: spd_pkg::PRED_W];

  // add/compare unit: candidate distance, saturated
  wire [25:0] cand_sum = 26'(min_d[spd_pkg::DIST_W-1:0]) + 26'(e_wt);
  wire [spd_pkg::DIST_W-1:0] cand =
    (cand_sum > 26'(spd_pkg::DIST_CAP)) ? spd_pkg::DIST_CAP : cand_sum[spd_pkg::DIST_W-1:0];
  wire [NA-1:0] t_idx = e_tgt[NA-1:0];
  wire [spd_pkg::DIST_W:0] t_dist = touched[t_idx] ? {1'b0, nd_dist} : spd_pkg::DIST_INF;
  wire [spd_pkg::DIST_W:0] j_dist = touched[scan_jd] ? {1'b0, nd_dist} : spd_pkg::DIST_INF;

  // accept-time checks
  wire edge_bad  = ({1'b0, in_data.edge_from} >= n_eff) || ({1'b0, in_data.edge_to} >= n_eff);
  wire query_bad = ({1'b0, in_data.query_start} >= n_eff) ||
                   ({1'b0, in_data.query_end} >= n_eff);
  wire query_same = (in_data.op == spd_pkg::OP_QUERY) && !query_bad &&
                    (in_data.query_start == in_data.query_end);

  // memory address and write steering
  always_comb begin
    hd_we    = 1'b0;
    hd_addr  = item.edge_from[NA-1:0];
    hd_wdata = edges_used;
    ed_we    = 1'b0;
    ed_addr  = edges_used[EA-1:0];
    ed_wdata = {item.edge_to, WEIGHT_BITS'(item.edge_cost),
                head_valid[item.edge_from[NA-1:0]] ? hd_rdata : EDGE_NULL};
    nd_we    = 1'b0;
    nd_waddr = t_idx;
    nd_wdata = {{1'b0, u_sel}, cand};
    nd_raddr = scan_j[NA-1:0];
    pb_we    = 1'b0;
    pb_raddr = idx[NA-1:0];
    case (state)
      S_IDLE: begin
        nd_we    = accept && in_data.op == spd_pkg::OP_QUERY;
        nd_waddr = in_data.query_start[NA-1:0];
        nd_wdata = {spd_pkg::NO_PRED, {spd_pkg::DIST_W{1'b0}}};
      end
      S_ADD_WR: begin
        hd_we = 1'b1;
        ed_we = 1'b1;
      end
      S_SEL: hd_addr = u_sel;
      S_EDGE: ed_addr = p[EA-1:0];
      S_EDGE_RD: begin
        // hold the edge read so the record stays in place for relaxation
        ed_addr  = p[EA-1:0];
        nd_raddr = t_idx;
      end
      S_REL: begin
        nd_raddr = t_idx;
        nd_we    = (cand_sum[25:0] < 26'(t_dist)) || ({1'b0, cand} < t_dist);
      end
      S_DRD, S_DCHK: nd_raddr = item.query_end[NA-1:0];
      S_WALK: begin
        nd_raddr = walk_v[NA-1:0];
        pb_we    = (walk_v < n_eff) && (cnt < n_eff);
      end
      S_WALK_RD: nd_raddr = walk_v[NA-1:0];
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_valid <= '0;
      edges_used <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            item       <= in_data;
            res_vertex <= query_same ? in_data.query_start : '0;
            case (in_data.op)
              spd_pkg::OP_ADD: begin
                if (edge_bad) begin
                  res_status <= spd_pkg::ST_EDGE_BAD;
                  state      <= S_RES;
                end else if (edges_used == EDGE_NULL) begin
                  res_status <= spd_pkg::ST_FULL;
                  state      <= S_RES;
                end else begin
                  state <= S_ADD;
                end
              end
              spd_pkg::OP_QUERY: begin
                if (query_bad) begin
                  res_status <= spd_pkg::ST_QUERY_BAD;
                  state      <= S_RES;
                end else if (in_data.query_start == in_data.query_end) begin
                  res_status <= spd_pkg::ST_PATH;
                  state      <= S_RES;
                end else begin
                  // seed the start node, everything else reads as infinite
                  touched <= MAX_NODES'(1) << in_data.query_start[NA-1:0];
                  done    <= '0;
                  rnd     <= 7'd0;
                  state   <= S_ROUND;
                end
              end
              spd_pkg::OP_CLEAR: begin
                head_valid <= '0;
                edges_used <= '0;
                res_status <= spd_pkg::ST_CLEARED;
                state      <= S_RES;
              end
              default: ;  // unused op: drop
            endcase
          end
        end
        S_RES: begin
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.vertex          <= res_vertex;
            out_data.total_distance  <= '0;
            out_data.status          <= res_status;
            out_data.last            <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        S_ADD: state <= S_ADD_WR;  // head read in flight
        S_ADD_WR: begin
          head_valid[item.edge_from[NA-1:0]] <= 1'b1;
          edges_used <= edges_used + 1'b1;
          res_status <= spd_pkg::ST_STORED;
          state      <= S_RES;
        end
        S_ROUND: begin
          if (rnd + 7'd1 >= n_eff) begin
            state <= S_DRD;
          end else begin
            scan_j  <= 7'd0;
            scan_pv <= 1'b0;
            min_d   <= spd_pkg::DIST_INF;
            u_none  <= 1'b1;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one node read per cycle, compare the previous one
          if (scan_j < n_eff) begin
            scan_pv <= 1'b1;
            scan_jd <= scan_j[NA-1:0];
            scan_j  <= scan_j + 7'd1;
          end else begin
            scan_pv <= 1'b0;
          end
          if (scan_pv && !done[scan_jd] && j_dist < min_d) begin
            min_d  <= j_dist;
            u_sel  <= scan_jd;
            u_none <= 1'b0;
          end
          if (scan_j >= n_eff && !scan_pv) state <= S_SEL;
        end
        S_SEL: begin
          if (u_none) begin
            state <= S_DRD;
          end else begin
            done[u_sel] <= 1'b1;
            state       <= S_HEAD;
          end
        end
        S_HEAD: begin
          p     <= head_valid[u_sel] ? hd_rdata : EDGE_NULL;
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (p >= EDGE_NULL) begin
            rnd   <= rnd + 7'd1;
            state <= S_ROUND;
          end else begin
            state <= S_EDGE_RD;
          end
        end
        S_EDGE_RD: begin
          p <= e_lnk;
          if (({1'b0, e_tgt} < n_eff) && !done[t_idx]) state <= S_REL;
          else state <= S_EDGE;
        end
        S_REL: begin
          if ({1'b0, cand} < t_dist) touched[t_idx] <= 1'b1;
          state <= S_EDGE;
        end
        S_DRD: state <= S_DCHK;
        S_DCHK: begin
          if (!touched[item.query_end[NA-1:0]]) begin
            res_status <= spd_pkg::ST_NO_PATH;
            state      <= S_RES;
          end else begin
            tot    <= nd_dist;
            walk_v <= {1'b0, item.query_end};
            cnt    <= 7'd0;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if ((walk_v < n_eff) && (cnt < n_eff)) begin
            cnt   <= cnt + 7'd1;
            state <= S_WALK_RD;
          end else begin
            idx   <= cnt - 7'd1;
            state <= S_EMIT;
          end
        end
        S_WALK_RD: begin
          walk_v <= nd_pred;
          state  <= S_WALK;
        end
        S_EMIT: state <= S_EMIT_LD;  // path buffer read in flight
        S_EMIT_LD: begin
          if (out_free) begin
            out_valid               <= 1'b1;
            out_data.vertex         <= pb_rdata;
            out_data.total_distance <= tot;
            out_data.status         <= spd_pkg::ST_PATH;
            out_data.last           <= (idx == 7'd0);
            if (idx == 7'd0) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - 7'd1;
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/spd_edge_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_edge_store: edge records and adjacency list heads
// Two single-port memories with registered read data.
// ----------------------------------------------------------------------------
module spd_edge_store #(
  parameter int MAX_NODES = spd_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = spd_pkg::MAX_EDGES_DEF,
  parameter int NA = $clog2(MAX_NODES),
  parameter int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int LB = $clog2(MAX_EDGES + 1),
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          hd_we,
  input  logic [NA-1:0] hd_addr,
  input  logic [LB-1:0] hd_wdata,
  output logic [LB-1:0] hd_rdata,
  input  logic          ed_we,
  input  logic [EA-1:0] ed_addr,
  input  logic [TW-1:0] ed_wdata,
  output logic [TW-1:0] ed_rdata
);

  logic [LB-1:0] head_mem [MAX_NODES];
  logic [TW-1:0] edge_mem [MAX_EDGES];

  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[hd_addr] <= hd_wdata;
    end
    hd_rdata <= head_mem[hd_addr];
  end

  always_ff @(posedge clk) begin
    if (ed_we) begin
      edge_mem[ed_addr] <= ed_wdata;
    end
    ed_rdata <= edge_mem[ed_addr];
  end

endmodule

### rtl/spd_node_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_node_table: per-node distance/predecessor and path buffer
// Node memory holds {predecessor, distance}; path buffer holds vertices.
// ----------------------------------------------------------------------------
module spd_node_table #(
  parameter int MAX_NODES = spd_pkg::MAX_NODES_DEF,
  parameter int NA = $clog2(MAX_NODES)
) (
  input  logic                           clk,
  input  logic                           nd_we,
  input  logic [NA-1:0]                  nd_waddr,
  input  logic [spd_pkg::NODE_W-1:0]     nd_wdata,
  input  logic [NA-1:0]                  nd_raddr,
  output logic [spd_pkg::NODE_W-1:0]     nd_rdata,
  input  logic                           pb_we,
  input  logic [NA-1:0]                  pb_waddr,
  input  logic [spd_pkg::VERTEX_W-1:0]   pb_wdata,
  input  logic [NA-1:0]                  pb_raddr,
  output logic [spd_pkg::VERTEX_W-1:0]   pb_rdata
);

  logic [spd_pkg::NODE_W-1:0]   node_mem [MAX_NODES];
  logic [spd_pkg::VERTEX_W-1:0] path_mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (nd_we) begin
      node_mem[nd_waddr] <= nd_wdata;
    end
    nd_rdata <= node_mem[nd_raddr];
  end

  always_ff @(posedge clk) begin
    if (pb_we) begin
      path_mem[pb_waddr] <= pb_wdata;
    end
    pb_rdata <= path_mem[pb_raddr];
  end

endmodule

### tb/sv/shortest_path_dijkstra_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_dijkstra_unit_tb: self-checking bench for the path unit
// Drives edge, query and clear words through the input channel, rewrites
// node_count between phases over APB, and checks every output word against
// an in-bench shortest path predictor or a typed expectation from the table.
// A directed table comes first, random phases under three idling patterns
// follow, and a short tail ends it.
module shortest_path_dijkstra_unit_tb;

  localparam int EDGE_SLOTS = 1024;
  localparam int NODE_SLOTS = 64;
  localparam int STALL_LIMIT = 100000;

  typedef struct {
    bit                 cfg;
    logic [6:0]         cnt_val;
    spd_pkg::in_word_t  w;
    bit                 typed;
    bit                 silent;
    spd_pkg::out_word_t r;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  spd_pkg::in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  spd_pkg::out_word_t out_data;
  logic      psel = 1'b0;
  logic      penable = 1'b0;
  logic      pwrite = 1'b0;
  logic      paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  shortest_path_dijkstra_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Predictor state: its own copy of the graph and of node_count.
  logic [5:0]  arc_target [EDGE_SLOTS];
  logic [15:0] arc_weight [EDGE_SLOTS];
  int          arc_next   [EDGE_SLOTS];
  int          adj_head   [NODE_SLOTS];
  int          arcs_used;
  logic [6:0]  node_cnt;

  spd_pkg::out_word_t route_q[$];  // expected output words, oldest first
  stim_row_t plan[$];              // directed stimulus table
  int tx_idle_pct = 0;        // sender gap chance, percent per cycle
  int rx_idle_pct = 0;        // receiver stall chance, percent per cycle
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int quiet_cycles = 0;
  int path_words = 0;

  function automatic void push_route(int v, int d, logic [2:0] st, bit lst);
    spd_pkg::out_word_t r;
    r.vertex = v[5:0];
    r.total_distance = d[21:0];
    r.status = st;
    r.last = lst;
    route_q.push_back(r);
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < NODE_SLOTS; i++) adj_head[i] = EDGE_SLOTS;
    arcs_used = 0;
  endfunction

  // Work out the output words that one accepted input word causes.
  function automatic void predict_route(spd_pkg::in_word_t w);
    int n, s, e, u, p, steps, cnt, v, k, mn, cand;
    int best_d[NODE_SLOTS];
    bit seen[NODE_SLOTS];
    int prv[NODE_SLOTS];
    int pbuf[NODE_SLOTS];
    n = (node_cnt == 0) ? 1 : ((node_cnt > NODE_SLOTS) ? NODE_SLOTS : int'(node_cnt));
    case (w.op)
      spd_pkg::OP_ADD: begin
        if (w.edge_from >= n || w.edge_to >= n) begin
          push_route(0, 0, spd_pkg::ST_EDGE_BAD, 1'b1);
        end else if (arcs_used >= EDGE_SLOTS) begin
          push_route(0, 0, spd_pkg::ST_FULL, 1'b1);
        end else begin
          k = arcs_used;
          arc_target[k] = w.edge_to;
          arc_weight[k] = w.edge_cost;
          arc_next[k] = adj_head[w.edge_from];
          adj_head[w.edge_from] = k;
          arcs_used = k + 1;
          push_route(0, 0, spd_pkg::ST_STORED, 1'b1);
        end
      end
      spd_pkg::OP_QUERY: begin
        s = w.query_start;
        e = w.query_end;
        if (s >= n || e >= n) begin
          push_route(0, 0, spd_pkg::ST_QUERY_BAD, 1'b1);
        end else if (s == e) begin
          push_route(s, 0, spd_pkg::ST_PATH, 1'b1);
        end else begin
          for (int i = 0; i < NODE_SLOTS; i++) begin
            best_d[i] = int'(spd_pkg::DIST_INF);
            seen[i] = 1'b0;
            prv[i] = int'(spd_pkg::NO_PRED);
          end
          best_d[s] = 0;
          for (int i = 0; i + 1 < n; i++) begin
            mn = int'(spd_pkg::DIST_INF);
            u = int'(spd_pkg::NO_PRED);
            // lowest index wins a tie: strict compare
            for (int j = 0; j < n; j++) begin
              if (!seen[j] && best_d[j] < mn) begin
                mn = best_d[j];
                u = j;
              end
            end
            if (u == int'(spd_pkg::NO_PRED)) break;
            seen[u] = 1'b1;
            p = adj_head[u];
            steps = 0;
            while (p < EDGE_SLOTS && steps < arcs_used) begin
              // skip targets beyond a shrunken node count
              if (arc_target[p] < n && !seen[arc_target[p]]) begin
                cand = best_d[u] + arc_weight[p];
                if (cand > int'(spd_pkg::DIST_CAP)) cand = int'(spd_pkg::DIST_CAP);
                if (cand < best_d[arc_target[p]]) begin
                  best_d[arc_target[p]] = cand;
                  prv[arc_target[p]] = u;
                end
              end
              p = arc_next[p];
              steps++;
            end
          end
          if (best_d[e] >= int'(spd_pkg::DIST_INF)) begin
            push_route(0, 0, spd_pkg::ST_NO_PATH, 1'b1);
          end else begin
            cnt = 0;
            v = e;
            while (v < n && cnt < n) begin
              pbuf[cnt++] = v;
              v = prv[v];
            end
            for (int i = 0; i < cnt; i++)
              push_route(pbuf[cnt - 1 - i], best_d[e], spd_pkg::ST_PATH, i + 1 == cnt);
          end
        end
      end
      spd_pkg::OP_CLEAR: begin
        wipe_graph();
        push_route(0, 0, spd_pkg::ST_CLEARED, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Build words with every unused field random, so all bits toggle.
  function automatic spd_pkg::in_word_t add_word(int f, int t, int c);
    spd_pkg::in_word_t w;
    w = spd_pkg::in_word_t'({$urandom, $urandom});
    w.op = spd_pkg::OP_ADD;
    w.edge_from = f[5:0];
    w.edge_to = t[5:0];
    w.edge_cost = c[15:0];
    return w;
  endfunction

  function automatic spd_pkg::in_word_t query_word(int s, int e);
    spd_pkg::in_word_t w;
    w = spd_pkg::in_word_t'({$urandom, $urandom});
    w.op = spd_pkg::OP_QUERY;
    w.query_start = s[5:0];
    w.query_end = e[5:0];
    return w;
  endfunction

  function automatic spd_pkg::in_word_t clear_word();
    spd_pkg::in_word_t w;
    w = spd_pkg::in_word_t'({$urandom, $urandom});
    w.op = spd_pkg::OP_CLEAR;
    return w;
  endfunction

  // Present one word, hold it until accepted, then predict its results.
  // A typed row replaces the predictor output with the given expectation.
  task automatic send_word(spd_pkg::in_word_t w, bit typed, bit silent,
                           spd_pkg::out_word_t r);
    int sz;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    sz = route_q.size();
    predict_route(w);
    if (typed) begin
      while (route_q.size() > sz) void'(route_q.pop_back());
      if (!silent) route_q.push_back(r);
    end
  endtask

  task automatic send_plain(spd_pkg::in_word_t w);
    send_word(w, 1'b0, 1'b0, '0);
  endtask

  // Drain everything, give an ignored word time to retire, then write.
  task automatic set_node_count(logic [6:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (route_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    node_cnt = value;
  endtask

  function automatic spd_pkg::out_word_t res(int v, logic [2:0] st);
    spd_pkg::out_word_t r;
    r.vertex = v[5:0];
    r.total_distance = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Table rows: checked against a typed result, predicted, silent, or config.
  function automatic stim_row_t row_chk(spd_pkg::in_word_t w, spd_pkg::out_word_t r);
    stim_row_t x;
    x.cfg = 1'b0;
    x.cnt_val = '0;
    x.w = w;
    x.typed = 1'b1;
    x.silent = 1'b0;
    x.r = r;
    return x;
  endfunction

  function automatic stim_row_t row_pred(spd_pkg::in_word_t w);
    stim_row_t x;
    x = row_chk(w, '0);
    x.typed = 1'b0;
    return x;
  endfunction

  function automatic stim_row_t row_quiet(spd_pkg::in_word_t w);
    stim_row_t x;
    x = row_chk(w, '0);
    x.silent = 1'b1;
    return x;
  endfunction

  function automatic stim_row_t row_cfg(logic [6:0] value);
    stim_row_t x;
    x = row_chk('0, '0);
    x.cfg = 1'b1;
    x.cnt_val = value;
    return x;
  endfunction

  // Output side: random stalls, and compare each accepted word in order.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
      if (out_valid && out_ready) begin
        words_checked++;
        if (route_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: vertex=%0d dist=%0d status=%0d last=%0b",
                     out_data.vertex, out_data.total_distance, out_data.status,
                     out_data.last);
        end else begin
          if (route_q[0].status == spd_pkg::ST_PATH) path_words++;
          if (out_data.vertex != route_q[0].vertex ||
              out_data.total_distance != route_q[0].total_distance ||
              out_data.status != route_q[0].status ||
              out_data.last != route_q[0].last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp v=%0d d=%0d st=%0d l=%0b got v=%0d d=%0d st=%0d l=%0b",
                       route_q[0].vertex, route_q[0].total_distance,
                       route_q[0].status, route_q[0].last, out_data.vertex,
                       out_data.total_distance, out_data.status, out_data.last);
          end
          void'(route_q.pop_front());
        end
      end
    end
  end

  // Watchdog: any accepted word on either channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("shortest_path_dijkstra_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [6:0] phase_n [6];
    int n, dice, f, t;
    phase_n = '{7'd5, 7'd127, 7'd0, 7'd16, 7'd3, 7'd64};
    node_cnt = 7'd64;
    wipe_graph();

    // Directed table, starting at the reset node count of 64.
    plan.push_back(row_chk(query_word(0, 0), res(0, spd_pkg::ST_PATH)));
    plan.push_back(row_chk(query_word(0, 1), res(0, spd_pkg::ST_NO_PATH)));
    plan.push_back(row_chk(add_word(63, 0, 16'hFFFF), res(0, spd_pkg::ST_STORED)));
    plan.push_back(row_chk(add_word(0, 63, 0), res(0, spd_pkg::ST_STORED)));
    plan.push_back(row_pred(add_word(0, 1, 1)));
    plan.push_back(row_chk(query_word(63, 63), res(63, spd_pkg::ST_PATH)));
    plan.push_back(row_pred(query_word(0, 63)));
    plan.push_back(row_pred(query_word(63, 1)));
    // Equal-cost routes: lowest index wins the tie.
    plan.push_back(row_pred(add_word(0, 2, 5)));
    plan.push_back(row_pred(add_word(0, 3, 5)));
    plan.push_back(row_pred(add_word(3, 4, 1)));
    plan.push_back(row_pred(add_word(2, 4, 1)));
    plan.push_back(row_pred(query_word(0, 4)));
    // Unused op code: all other bits high, no result.
    plan.push_back(row_quiet(spd_pkg::in_word_t'({2'd3, 40'hFF_FFFF_FFFF})));
    plan.push_back(row_chk(clear_word(), res(0, spd_pkg::ST_CLEARED)));
    plan.push_back(row_chk(query_word(63, 0), res(0, spd_pkg::ST_NO_PATH)));
    // Edge beyond the count to come, to be skipped after shrinking.
    plan.push_back(row_pred(add_word(1, 40, 2)));
    plan.push_back(row_pred(add_word(1, 2, 3)));
    plan.push_back(row_cfg(7'd8));
    plan.push_back(row_chk(add_word(8, 0, 7), res(0, spd_pkg::ST_EDGE_BAD)));
    plan.push_back(row_chk(add_word(0, 63, 7), res(0, spd_pkg::ST_EDGE_BAD)));
    plan.push_back(row_chk(query_word(9, 0), res(0, spd_pkg::ST_QUERY_BAD)));
    plan.push_back(row_chk(query_word(0, 63), res(0, spd_pkg::ST_QUERY_BAD)));
    plan.push_back(row_pred(query_word(1, 2)));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg) set_node_count(plan[i].cnt_val);
      else send_word(plan[i].w, plan[i].typed, plan[i].silent, plan[i].r);
    end

    // Random phases: two per idling pattern, each at its own node count.
    for (int ph = 0; ph < 6; ph++) begin
      set_node_count(phase_n[ph]);
      tx_idle_pct = (ph < 2) ? 6 : ((ph < 4) ? 83 : 0);
      rx_idle_pct = (ph < 2) ? 83 : ((ph < 4) ? 6 : 0);
      n = (phase_n[ph] == 0) ? 1 : ((phase_n[ph] > 64) ? 64 : int'(phase_n[ph]));
      send_plain(clear_word());
      for (int i = 0; i < 13; i++) begin
        dice = $urandom_range(99);
        f = $urandom_range(n - 1);
        t = $urandom_range(n - 1);
        if (dice < 50) begin
          send_plain(add_word(f, t, (dice < 10) ? $urandom_range(3) : $urandom));
        end else if (dice < 82) begin
          send_plain(query_word(f, t));
        end else if (dice < 86) begin
          send_plain(clear_word());
        end else if (dice < 90) begin
          send_plain(spd_pkg::in_word_t'({2'd3, 8'($urandom), $urandom}));
        end else begin
          // noise: op codes 0 to 2 with any other field values
          send_plain(spd_pkg::in_word_t'({2'($urandom_range(2)), 8'($urandom), $urandom}));
        end
      end
    end

    // Short tail at a small node count.
    set_node_count(7'd4);
    send_plain(clear_word());
    send_plain(add_word(2, 3, 4));
    send_plain(query_word(2, 3));

    in_valid <= 1'b0;
    @(posedge clk);
    while (route_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("run covered %0d input words and %0d output words (%0d path vertices)",
             words_sent, words_checked, path_words);
    $display("node counts 64, 8, 5, 127, 0, 16, 3, 64, 4 under three idling patterns");
    if (mismatches == 0 && route_q.size() == 0) begin
      $display("shortest_path_dijkstra_unit_tb: clean");
    end else begin
      $display("%0d mismatches, %0d words still expected", mismatches, route_q.size());
      $display("shortest_path_dijkstra_unit_tb: errors");
    end
    $finish;
  end

endmodule
